// ----- sv/dps_pkg.sv -----
// ----------------------------------------------------------------------------
// dps_pkg
// Shared types and codes of the DEC private mode sniffer.
// ----------------------------------------------------------------------------
`default_nettype none

package dps_pkg;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_of_write;
  } in_item_t;

  typedef struct packed {
    logic [2:0] mode_event;
    logic       cursor_app_mode;
    logic       mouse_reporting;
  } out_item_t;

  localparam logic [2:0] EV_NONE       = 3'd0;
  localparam logic [2:0] EV_CURSOR_ON  = 3'd1;
  localparam logic [2:0] EV_CURSOR_OFF = 3'd2;
  localparam logic [2:0] EV_MOUSE_ON   = 3'd3;
  localparam logic [2:0] EV_MOUSE_OFF  = 3'd4;

endpackage

`default_nettype wire

// ----- sv/dps_parse.sv -----
// ----------------------------------------------------------------------------
// dps_parse
// Escape sequence parser: holds the parse state and the mode flags and
// forms one result for every accepted byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_parse
  import dps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      accept,
  input  wire in_item_t  item,
  output out_item_t      result
);

  typedef enum logic [1:0] {
    PH_PLAIN   = 2'd0,
    PH_ESC     = 2'd1,
    PH_BRACKET = 2'd2,
    PH_NUMBER  = 2'd3
  } phase_t;

  localparam logic [7:0] CH_ESC     = 8'h1B;
  localparam logic [7:0] CH_LBRACK  = 8'h5B;
  localparam logic [7:0] CH_QUEST   = 8'h3F;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_SEMI    = 8'h3B;
  localparam logic [7:0] CH_SET     = 8'h68;
  localparam logic [7:0] CH_RESET   = 8'h6C;

  localparam logic [31:0] MOUSE_A = 32'd1000;
  localparam logic [31:0] MOUSE_B = 32'd1002;
  localparam logic [31:0] MOUSE_C = 32'd1006;
  localparam logic [31:0] MOUSE_D = 32'd1015;

  phase_t      phase_r, phase_nxt;
  logic [31:0] number_r, number_nxt;
  logic        seen_r, seen_nxt;
  logic        cursor_r, cursor_nxt;
  logic        mouse_r, mouse_nxt;
  logic [2:0]  event_code;
  logic        is_mouse;
  logic        is_digit;
  logic        set_cmd;
  logic [7:0]  digit;

  assign is_mouse = (number_r == MOUSE_A) || (number_r == MOUSE_B) ||
                    (number_r == MOUSE_C) || (number_r == MOUSE_D);
  assign is_digit = (item.byte_value >= CH_ZERO) && (item.byte_value <= CH_NINE);
  assign set_cmd  = (item.byte_value == CH_SET);
  assign digit    = item.byte_value - CH_ZERO;

  always_comb begin
    phase_nxt  = phase_r;
    number_nxt = number_r;
    seen_nxt   = seen_r;
    cursor_nxt = cursor_r;
    mouse_nxt  = mouse_r;
    event_code = EV_NONE;
    unique case (phase_r)
      PH_PLAIN: begin
        if (item.byte_value == CH_ESC) begin
          phase_nxt = PH_ESC;
        end
      end
      PH_ESC: begin
        phase_nxt = (item.byte_value == CH_LBRACK) ? PH_BRACKET : PH_PLAIN;
      end
      PH_BRACKET: begin
        if (item.byte_value == CH_QUEST) begin
          phase_nxt  = PH_NUMBER;
          number_nxt = '0;
        end else begin
          phase_nxt = PH_PLAIN;
        end
      end
      PH_NUMBER: begin
        priority if (is_digit) begin
          number_nxt = (number_r << 3) + (number_r << 1) + {24'd0, digit};
        end else if (item.byte_value == CH_SEMI) begin
          if (is_mouse) begin
            seen_nxt = 1'b1;
          end
          number_nxt = '0;
        end else if (set_cmd || (item.byte_value == CH_RESET)) begin
          phase_nxt = PH_PLAIN;
          if (number_r == 32'd1) begin
            cursor_nxt = set_cmd;
            event_code = set_cmd ? EV_CURSOR_ON : EV_CURSOR_OFF;
          end else if (is_mouse || seen_r) begin
            seen_nxt   = 1'b1;
            mouse_nxt  = set_cmd;
            event_code = set_cmd ? EV_MOUSE_ON : EV_MOUSE_OFF;
          end
        end else begin
          phase_nxt = PH_NUMBER;
        end
      end
      default: begin
        phase_nxt = PH_PLAIN;
      end
    endcase
    if (item.last_of_write) begin
      phase_nxt  = PH_PLAIN;
      number_nxt = '0;
      seen_nxt   = 1'b0;
    end
  end

  assign result.mode_event      = event_code;
  assign result.cursor_app_mode = cursor_nxt;
  assign result.mouse_reporting = mouse_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_PLAIN;
      number_r <= '0;
      seen_r   <= 1'b0;
      cursor_r <= 1'b0;
      mouse_r  <= 1'b0;
    end else if (accept) begin
      phase_r  <= phase_nxt;
      number_r <= number_nxt;
      seen_r   <= seen_nxt;
      cursor_r <= cursor_nxt;
      mouse_r  <= mouse_nxt;
    end
  end

  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    accept && item.last_of_write |=> phase_r == PH_PLAIN && number_r == '0 && !seen_r)
    else $error("end of write did not clear parse state");

  a_cursor_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (result.mode_event == EV_CURSOR_ON || result.mode_event == EV_CURSOR_OFF)
    |=> cursor_r == $past(result.mode_event == EV_CURSOR_ON))
    else $error("cursor flag does not follow cursor event");

  a_mouse_event: assert property (@(posedge clk) disable iff (!rst_n)
    accept && (result.mode_event == EV_MOUSE_ON || result.mode_event == EV_MOUSE_OFF)
    |=> mouse_r == $past(result.mode_event == EV_MOUSE_ON))
    else $error("mouse flag does not follow mouse event");

endmodule

`default_nettype wire

// ----- sv/dps_obuf.sv -----
// ----------------------------------------------------------------------------
// dps_obuf
// Result register with one skid entry; parts the input stall from the
// output stall so that a byte can enter while a result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module dps_obuf
  import dps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      wr_en,
  input  wire out_item_t wr_data,
  output logic           full,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      out_valid_r;
  out_item_t out_data_r;
  logic      skid_valid_r;
  out_item_t skid_data_r;
  logic      out_take;

  assign out_take  = out_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_take) begin
        out_data_r   <= skid_data_r;
        skid_valid_r <= 1'b0;
      end
    end else if (wr_en) begin
      if (!out_valid_r || out_take) begin
        out_data_r  <= wr_data;
        out_valid_r <= 1'b1;
      end else begin
        skid_data_r  <= wr_data;
        skid_valid_r <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty result register");

  a_no_write_full: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> !skid_valid_r)
    else $error("write into full buffer");

  a_skid_drains: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && out_take |=> out_valid_r && !skid_valid_r)
    else $error("skid entry lost on transfer");

endmodule

`default_nettype wire

// ----- sv/dec_private_mode_sniffer.sv -----
// ----------------------------------------------------------------------------
// dec_private_mode_sniffer
// Watches terminal output bytes for DEC private mode set/reset sequences
// and reports cursor-key application and mouse reporting changes.
//
// Input channel: in_valid / in_stall / in_data carry one byte and an
// end-of-write mark. A transfer happens on a rising edge with valid high
// and stall low. Output channel: out_valid / out_stall / out_data carry one
// result per byte: the mode event and both current flags.
// Throughput: one byte per cycle while in_stall is low; the whole parse step
// runs in the cycle of the transfer and the result lands in the output
// register, or in the skid entry while a stalled result waits there.
// Stall: a two-entry output buffer absorbs one result while out_stall is
// high; in_stall rises only when both entries hold results, and is a
// register output.
// Reset (rst_n low, synchronous): plain-text phase, value and flags clear,
// output buffer empties.
// ----------------------------------------------------------------------------
`default_nettype none

module dec_private_mode_sniffer
  import dps_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic      in_accept;
  out_item_t result;
  logic      buf_full;

  assign in_stall  = buf_full;
  assign in_accept = in_valid && !buf_full;

  dps_parse u_parse (
    .clk    (clk),
    .rst_n  (rst_n),
    .accept (in_accept),
    .item   (in_data),
    .result (result)
  );

  dps_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (in_accept),
    .wr_data   (result),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire
